// ===== hw/rtl/ssi_pkg.sv =====
// Shared constants and types for the segment/sphere intersection unit.
// No dependencies; every other file uses this package.
package ssi_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // early verdict from the setup stages
  typedef struct packed {
    logic enclosed;
    logic miss;
  } ssi_flags_t;

endpackage

// ===== hw/rtl/ssi_if.sv =====
// Valid/ready stream interfaces for query and result words.
// Depends on ssi_pkg for default widths.
interface ssi_query_if #(
  parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;
  logic signed [COORD_WIDTH-1:0] centre_x;
  logic signed [COORD_WIDTH-1:0] centre_y;
  logic signed [COORD_WIDTH-1:0] centre_z;
  logic        [COORD_WIDTH-2:0] sphere_radius;

  modport source (
    output valid, start_x, start_y, start_z, end_x, end_y, end_z,
    output centre_x, centre_y, centre_z, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
    input  centre_x, centre_y, centre_z, sphere_radius,
    output ready
  );
endinterface

interface ssi_result_if #(
  parameter int unsigned FRACTION_BITS = ssi_pkg::FRACTION_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [FRACTION_BITS:0] entry_fraction;

  modport source (output valid, hit, entry_fraction, input ready);
  modport sink (input valid, hit, entry_fraction, output ready);
endinterface

// ===== hw/rtl/segment_sphere_intersect_unit.sv =====
// Segment/sphere intersection unit, fully pipelined.
// Throughput: one query word per cycle while the skid entry is empty; a two-entry output buffer absorbs stalls.
// Reset: rst_ni async active low clears all valid bits and the output buffer.
// Depends on ssi_pkg, ssi_if, ssi_prep, ssi_disc, ssi_sqrt, ssi_div.
module segment_sphere_intersect_unit #(
  parameter int unsigned COORD_WIDTH   = ssi_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = ssi_pkg::FRACTION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ssi_query_if.sink     query_i,
  ssi_result_if.source  result_o
);
  import ssi_pkg::*;

  localparam int unsigned AW    = 2 * COORD_WIDTH + 2;
  localparam int unsigned PW    = 2 * AW;
  localparam int unsigned XW    = PW + 2 * FRACTION_BITS;
  localparam int unsigned SW    = XW / 2;
  localparam int unsigned QW    = FRACTION_BITS + 1;
  localparam int unsigned DSIDE = 2 * AW + $bits(ssi_flags_t);
  localparam int unsigned SSIDE = 2 * AW + 2;

  logic                          en;
  logic signed [COORD_WIDTH-1:0] start_c  [3];
  logic signed [COORD_WIDTH-1:0] end_c    [3];
  logic signed [COORD_WIDTH-1:0] centre_c [3];

  logic             p_v;
  logic [AW-1:0]    p_g, p_aa, p_c;
  ssi_flags_t       p_flags, d_flags;

  logic             d_v, d_neg, d_hit, d_tv;
  logic [PW-1:0]    d_dd;
  logic [DSIDE-1:0] d_side;
  logic [AW-1:0]    d_g, d_aa;

  logic             s_v, s_nz;
  logic [SW-1:0]    s_root;
  logic [SSIDE-1:0] s_side;
  logic [AW-1:0]    s_g, s_aa;

  logic             m_v_q;
  logic [SW-1:0]    m_d, m_q;
  logic [AW-1:0]    m_aa_q;
  logic [1:0]       m_vd_q;

  logic             q_v;
  logic [QW-1:0]    q_val;
  logic [1:0]       q_vd;
  logic             res_hit;
  logic [QW-1:0]    res_frac;

  logic             out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic             out_hit_d, out_hit_q, skid_hit_d, skid_hit_q;
  logic [QW-1:0]    out_frac_d, out_frac_q, skid_frac_d, skid_frac_q;

  assign en            = !skid_v_q;
  assign query_i.ready = en;

  assign start_c  = '{query_i.start_x, query_i.start_y, query_i.start_z};
  assign end_c    = '{query_i.end_x, query_i.end_y, query_i.end_z};
  assign centre_c = '{query_i.centre_x, query_i.centre_y, query_i.centre_z};

  ssi_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (query_i.valid),
    .start_i  (start_c),
    .end_i    (end_c),
    .centre_i (centre_c),
    .radius_i (query_i.sphere_radius),
    .valid_o  (p_v),
    .g_o      (p_g),
    .aa_o     (p_aa),
    .c_o      (p_c),
    .flags_o  (p_flags)
  );

  ssi_disc #(.AW(AW), .SIDEW(DSIDE)) u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p_v),
    .g_i     (p_g),
    .aa_i    (p_aa),
    .c_i     (p_c),
    .side_i  ({p_g, p_aa, p_flags}),
    .valid_o (d_v),
    .neg_o   (d_neg),
    .dd_o    (d_dd),
    .side_o  (d_side)
  );

  assign d_g     = d_side[DSIDE-1 -: AW];
  assign d_aa    = d_side[DSIDE-AW-1 -: AW];
  assign d_flags = ssi_flags_t'(d_side[$bits(ssi_flags_t)-1:0]);
  assign d_hit   = d_flags.enclosed || !(d_flags.miss || d_neg);
  assign d_tv    = !d_flags.enclosed && !(d_flags.miss || d_neg);

  ssi_sqrt #(.XW(XW), .SIDEW(SSIDE)) u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (d_v),
    .x_i      ({d_dd, {(2*FRACTION_BITS){1'b0}}}),
    .side_i   ({d_g, d_aa, d_hit, d_tv}),
    .valid_o  (s_v),
    .root_o   (s_root),
    .rem_nz_o (s_nz),
    .side_o   (s_side)
  );

  assign s_g  = s_side[SSIDE-1 -: AW];
  assign s_aa = s_side[SSIDE-AW-1 -: AW];
  assign m_d  = {s_g, {FRACTION_BITS{1'b0}}} - s_root - SW'(s_nz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
    end else if (en) begin
      m_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= m_d;
      m_aa_q <= s_aa;
      m_vd_q <= s_side[1:0];
    end
  end

  ssi_div #(.AW(AW), .QW(QW), .SIDEW(2)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_v_q),
    .m_i     (m_q),
    .aa_i    (m_aa_q),
    .side_i  (m_vd_q),
    .valid_o (q_v),
    .q_o     (q_val),
    .side_o  (q_vd)
  );

  assign res_hit  = q_vd[1];
  assign res_frac = q_vd[0] ? q_val : '0;

  always_comb begin
    out_v_d     = out_v_q;
    out_hit_d   = out_hit_q;
    out_frac_d  = out_frac_q;
    skid_v_d    = skid_v_q;
    skid_hit_d  = skid_hit_q;
    skid_frac_d = skid_frac_q;
    if (!out_v_q || result_o.ready) begin
      if (skid_v_q) begin
        out_v_d    = 1'b1;
        out_hit_d  = skid_hit_q;
        out_frac_d = skid_frac_q;
        skid_v_d   = 1'b0;
      end else begin
        out_v_d    = q_v;
        out_hit_d  = res_hit;
        out_frac_d = res_frac;
      end
    end else if (q_v && en) begin
      skid_v_d    = 1'b1;
      skid_hit_d  = res_hit;
      skid_frac_d = res_frac;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q   <= out_hit_d;
    out_frac_q  <= out_frac_d;
    skid_hit_q  <= skid_hit_d;
    skid_frac_q <= skid_frac_d;
  end

  assign result_o.valid          = out_v_q;
  assign result_o.hit            = out_hit_q;
  assign result_o.entry_fraction = out_frac_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without output entry");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(result_o.valid && !result_o.ready))
    else $error("skid filled while output was free");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.hit |-> result_o.entry_fraction == '0)
    else $error("miss word with nonzero fraction");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.entry_fraction <= {1'b1, {FRACTION_BITS{1'b0}}})
    else $error("entry fraction above one");

endmodule

// ===== hw/rtl/ssi_prep.sv =====
// Setup pipeline: offsets, squares, dot products and early verdict (4 stages).
// Depends on ssi_pkg.
module ssi_prep #(
  parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] start_i [3],
  input  logic signed [COORD_WIDTH-1:0] end_i [3],
  input  logic signed [COORD_WIDTH-1:0] centre_i [3],
  input  logic        [COORD_WIDTH-2:0] radius_i,
  output logic                          valid_o,
  output logic [2*COORD_WIDTH+1:0]      g_o,
  output logic [2*COORD_WIDTH+1:0]      aa_o,
  output logic [2*COORD_WIDTH+1:0]      c_o,
  output ssi_pkg::ssi_flags_t           flags_o
);
  import ssi_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned AW = 2 * COORD_WIDTH + 2;
  localparam int unsigned HW = AW + 1;
  localparam int unsigned RW = 2 * COORD_WIDTH - 2;

  logic                   v1_q, v2_q, v3_q, v4_q;
  logic signed [DW-1:0]   sk_d [3];
  logic signed [DW-1:0]   dk_d [3];
  logic signed [DW-1:0]   sk_q [3];
  logic signed [DW-1:0]   dk_q [3];
  logic [COORD_WIDTH-2:0] rad_q;
  logic signed [AW-1:0]   sqs_d [3];
  logic signed [AW-1:0]   sqd_d [3];
  logic signed [AW-1:0]   crs_d [3];
  logic signed [AW-1:0]   sqs_q [3];
  logic signed [AW-1:0]   sqd_q [3];
  logic signed [AW-1:0]   crs_q [3];
  logic [RW-1:0]          rr_d, rr_q;
  logic [AW-1:0]          ss_d, aa_d, rr3_d;
  logic [AW-1:0]          ss_q, aa_q, rr3_q;
  logic signed [HW-1:0]   h_d, h_q;
  logic [AW-1:0]          g_d, c_d, g4_q, aa4_q, c4_q;
  logic                   far;
  ssi_flags_t             flags_d, flags_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sk_d[k]  = DW'(start_i[k]) - DW'(centre_i[k]);
      dk_d[k]  = DW'(end_i[k]) - DW'(start_i[k]);
      sqs_d[k] = sk_q[k] * sk_q[k];
      sqd_d[k] = dk_q[k] * dk_q[k];
      crs_d[k] = sk_q[k] * dk_q[k];
    end
    rr_d  = rad_q * rad_q;
    ss_d  = $unsigned(sqs_q[0]) + $unsigned(sqs_q[1]) + $unsigned(sqs_q[2]);
    aa_d  = $unsigned(sqd_q[0]) + $unsigned(sqd_q[1]) + $unsigned(sqd_q[2]);
    h_d   = HW'(crs_q[0]) + HW'(crs_q[1]) + HW'(crs_q[2]);
    rr3_d = AW'(rr_q);
    g_d   = AW'(-h_q);
    c_d   = ss_q - rr3_q;
    far   = (g_d > aa_q) && (({1'b0, aa_q} + {1'b0, c_d}) > {g_d, 1'b0});
    flags_d.enclosed = ss_q <= rr3_q;
    flags_d.miss     = (aa_q == '0) || !h_q[HW-1] || far;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sk_q    <= sk_d;
      dk_q    <= dk_d;
      rad_q   <= radius_i;
      sqs_q   <= sqs_d;
      sqd_q   <= sqd_d;
      crs_q   <= crs_d;
      rr_q    <= rr_d;
      ss_q    <= ss_d;
      aa_q    <= aa_d;
      h_q     <= h_d;
      rr3_q   <= rr3_d;
      g4_q    <= g_d;
      aa4_q   <= aa_q;
      c4_q    <= c_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = v4_q;
  assign g_o     = g4_q;
  assign aa_o    = aa4_q;
  assign c_o     = c4_q;
  assign flags_o = flags_q;

endmodule

// ===== hw/rtl/ssi_disc.sv =====
// Discriminant pipeline: g*g - aa*c from split partial products (3 stages).
// Depends on ssi_pkg.
module ssi_disc #(
  parameter int unsigned AW    = 2 * ssi_pkg::COORD_WIDTH_DEF + 2,
  parameter int unsigned SIDEW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [AW-1:0]     g_i,
  input  logic [AW-1:0]     aa_i,
  input  logic [AW-1:0]     c_i,
  input  logic [SIDEW-1:0]  side_i,
  output logic              valid_o,
  output logic              neg_o,
  output logic [2*AW-1:0]   dd_o,
  output logic [SIDEW-1:0]  side_o
);
  import ssi_pkg::*;

  localparam int unsigned H  = (AW + 1) / 2;
  localparam int unsigned PW = 2 * AW;

  logic [2*H-1:0]   ge, ae, ce;
  logic [2*H-1:0]   gg_hh_q, gg_hl_q, gg_ll_q;
  logic [2*H-1:0]   ac_hh_q, ac_hl_q, ac_lh_q, ac_ll_q;
  logic [4*H-1:0]   g2_d, ac_d, g2_q, ac_q;
  logic             neg_d, neg_q;
  logic [PW-1:0]    dd_d, dd_q;
  logic             v1_q, v2_q, v3_q;
  logic [SIDEW-1:0] s1_q, s2_q, s3_q;

  assign ge = (2*H)'(g_i);
  assign ae = (2*H)'(aa_i);
  assign ce = (2*H)'(c_i);

  always_comb begin
    g2_d  = {gg_hh_q, gg_ll_q} + ((4*H)'(gg_hl_q) << (H + 1));
    ac_d  = {ac_hh_q, ac_ll_q} + ((4*H)'(ac_hl_q) << H) + ((4*H)'(ac_lh_q) << H);
    neg_d = ac_q > g2_q;
    dd_d  = PW'(g2_q - ac_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gg_hh_q <= ge[2*H-1:H] * ge[2*H-1:H];
      gg_hl_q <= ge[2*H-1:H] * ge[H-1:0];
      gg_ll_q <= ge[H-1:0] * ge[H-1:0];
      ac_hh_q <= ae[2*H-1:H] * ce[2*H-1:H];
      ac_hl_q <= ae[2*H-1:H] * ce[H-1:0];
      ac_lh_q <= ae[H-1:0] * ce[2*H-1:H];
      ac_ll_q <= ae[H-1:0] * ce[H-1:0];
      g2_q    <= g2_d;
      ac_q    <= ac_d;
      neg_q   <= neg_d;
      dd_q    <= dd_d;
      s1_q    <= side_i;
      s2_q    <= s1_q;
      s3_q    <= s2_q;
    end
  end

  assign valid_o = v3_q;
  assign neg_o   = neg_q;
  assign dd_o    = dd_q;
  assign side_o  = s3_q;

endmodule

// ===== hw/rtl/ssi_sqrt.sv =====
// Integer square root, one root bit per stage, with a remainder-nonzero flag.
// Depends on ssi_pkg.
module ssi_sqrt #(
  parameter int unsigned XW    = 4 * ssi_pkg::COORD_WIDTH_DEF + 4
                                 + 2 * ssi_pkg::FRACTION_BITS_DEF,
  parameter int unsigned SIDEW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [XW-1:0]     x_i,
  input  logic [SIDEW-1:0]  side_i,
  output logic              valid_o,
  output logic [XW/2-1:0]   root_o,
  output logic              rem_nz_o,
  output logic [SIDEW-1:0]  side_o
);
  import ssi_pkg::*;

  localparam int unsigned SW = XW / 2;
  localparam int unsigned RW = SW + 2;

  logic [XW-1:0]    x_q    [SW-1];
  logic [SW-1:0]    root_q [SW];
  logic [RW-1:0]    rem_q  [SW];
  logic [SIDEW-1:0] side_q [SW];
  logic             v_q    [SW];

  for (genvar i = 0; i < SW; i++) begin : g_stage
    logic [XW-1:0]    x_in;
    logic [SW-1:0]    root_in;
    logic [RW-1:0]    rem_in, rem_t, trial;
    logic [SIDEW-1:0] side_in;
    logic             v_in, ge;

    if (i == 0) begin : g_head
      assign x_in    = x_i;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_link
      assign x_in    = x_q[i-1];
      assign root_in = root_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign side_in = side_q[i-1];
      assign v_in    = v_q[i-1];
    end

    assign rem_t = {rem_in[RW-3:0], x_in[XW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i] <= {root_in[SW-2:0], ge};
        rem_q[i]  <= ge ? rem_t - trial : rem_t;
        side_q[i] <= side_in;
      end
    end

    if (i < SW - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[i] <= x_in << 2;
        end
      end
    end
  end

  assign valid_o  = v_q[SW-1];
  assign root_o   = root_q[SW-1];
  assign rem_nz_o = rem_q[SW-1] != '0;
  assign side_o   = side_q[SW-1];

endmodule

// ===== hw/rtl/ssi_div.sv =====
// Restoring divider, one quotient bit per stage, quotient below 2^QW.
// Depends on ssi_pkg.
module ssi_div #(
  parameter int unsigned AW    = 2 * ssi_pkg::COORD_WIDTH_DEF + 2,
  parameter int unsigned QW    = ssi_pkg::FRACTION_BITS_DEF + 1,
  parameter int unsigned SIDEW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [AW+QW-2:0]   m_i,
  input  logic [AW-1:0]      aa_i,
  input  logic [SIDEW-1:0]   side_i,
  output logic               valid_o,
  output logic [QW-1:0]      q_o,
  output logic [SIDEW-1:0]   side_o
);
  import ssi_pkg::*;

  localparam int unsigned CW = AW + QW;

  logic [CW-1:0]    rem_q  [QW-1];
  logic [AW-1:0]    aa_q   [QW-1];
  logic [QW-1:0]    q_q    [QW];
  logic [SIDEW-1:0] side_q [QW];
  logic             v_q    [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [CW-1:0]    rem_in, dsh;
    logic [AW-1:0]    aa_in;
    logic [QW-1:0]    q_in;
    logic [SIDEW-1:0] side_in;
    logic             v_in, ge;

    if (j == 0) begin : g_head
      assign rem_in  = CW'(m_i);
      assign aa_in   = aa_i;
      assign q_in    = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_link
      assign rem_in  = rem_q[j-1];
      assign aa_in   = aa_q[j-1];
      assign q_in    = q_q[j-1];
      assign side_in = side_q[j-1];
      assign v_in    = v_q[j-1];
    end

    assign dsh = CW'(aa_in) << (QW - 1 - j);
    assign ge  = rem_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j]    <= {q_in[QW-2:0], ge};
        side_q[j] <= side_in;
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j] <= ge ? rem_in - dsh : rem_in;
          aa_q[j]  <= aa_in;
        end
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign q_o     = q_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule
